FILE: rtl/tick_driven_repeat_timer_table_core_macros.svh
// Assertion macros shared by the timer table checker.
`ifndef TICK_DRIVEN_REPEAT_TIMER_TABLE_CORE_MACROS_SVH
`define TICK_DRIVEN_REPEAT_TIMER_TABLE_CORE_MACROS_SVH

// Same-cycle implication, muted during reset.
`define TRTT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer table check failed");

// Next-cycle implication, muted during reset.
`define TRTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer table check failed");

`endif

FILE: rtl/trtt_pkg.sv
// ----------------------------------------------------------------------------
// trtt_pkg
// Types and constants for the tick driven repeat timer table.
// ----------------------------------------------------------------------------
package trtt_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int RESULT_MAX     = 8;
  localparam int FIRE_CNT_W     = $clog2(RESULT_MAX + 1);
  localparam int OP_W           = 3;
  localparam int KEY_W          = 8;
  localparam int PERIOD_W       = 16;
  localparam int REPEAT_W       = 8;
  localparam int COUNTER_W      = 17;
  localparam int IDX_OUT_W      = 3;

  localparam logic [COUNTER_W-1:0] COUNTER_ONE = COUNTER_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_SETUP  = 3'd1,
    OP_START  = 3'd2,
    OP_STOP   = 3'd3,
    OP_DELETE = 3'd4
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [KEY_W-1:0]    owner_key;
    logic [PERIOD_W-1:0] period_ticks;
    logic [REPEAT_W-1:0] repeat_count;
  } cmd_t;

  typedef struct packed {
    logic                 fired;
    logic [KEY_W-1:0]     fired_key;
    logic [IDX_OUT_W-1:0] slot_index;
    logic                 status;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [KEY_W-1:0]     owner;
    logic [COUNTER_W-1:0] counter;
    logic [PERIOD_W-1:0]  period;
    logic [REPEAT_W-1:0]  repeats_left;
  } slot_t;

  typedef struct packed {
    logic hit;
    logic fire;
  } upd_flags_t;

  localparam slot_t SLOT_RESET = '{
    owner:        '0,
    counter:      COUNTER_ONE,
    period:       '0,
    repeats_left: '0
  };

endpackage

FILE: rtl/tick_driven_repeat_timer_table_core.sv
// ----------------------------------------------------------------------------
// tick_driven_repeat_timer_table_core
// Multi-channel periodic timer table with per-slot repeat counts.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. A tick walks
// every slot through one memory read port and one write port, one slot per
// cycle, and holds busy through the walk and a closing state; setup, start,
// stop and delete walk until the first hit or the end of the table, holding
// busy meanwhile. An unknown operation is answered on the next
// cycle without raising busy. Results come out as one-cycle beats on result,
// marked by strobe; the receiver cannot stall them, so it must take every
// strobe. A tick gives one beat per fired slot in slot order (at most eight;
// later fires still update their slots) and none if nothing fires; the final
// beat of a command carries last. Every other command gives exactly one beat.
// No memory clearing pass is needed: per-entry written flags stand in for the
// reset contents.
// ----------------------------------------------------------------------------
module tick_driven_repeat_timer_table_core
  import trtt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t                state;
  cmd_t                  cmd_q;
  logic [CNT_W-1:0]      rd_cnt;
  logic                  proc_vld;
  logic [IDX_W-1:0]      proc_idx;
  logic                  pend_vld;
  result_t               pend;
  logic [FIRE_CNT_W-1:0] fire_cnt;

  logic       accept;
  logic       issue;
  logic       is_tick;
  logic       last_slot;
  logic       fire_beat;
  logic       search_done;
  slot_t      rd_data;
  slot_t      entry_next;
  upd_flags_t flags;
  logic       wr_en;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign issue     = (state == ST_WALK) && (rd_cnt != CNT_W'(SLOT_COUNT));
  assign is_tick   = (cmd_q.operation == OP_TICK);
  assign last_slot = (proc_idx == IDX_W'(SLOT_COUNT - 1));
  // A reportable fire, and the end of a search (hit or table exhausted).
  assign fire_beat   = is_tick && flags.fire && (fire_cnt < FIRE_CNT_W'(RESULT_MAX));
  assign search_done = !is_tick && (flags.hit || last_slot);
  // Write back every ticked slot, and a search slot only on its hit.
  assign wr_en     = (state == ST_WALK) && proc_vld && (is_tick || flags.hit);

  trtt_slot_ram #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (issue),
    .rd_addr (rd_cnt[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (proc_idx),
    .wr_data (entry_next)
  );

  trtt_slot_update u_upd (
    .operation    (cmd_q.operation),
    .owner_key    (cmd_q.owner_key),
    .period_ticks (cmd_q.period_ticks),
    .repeat_count (cmd_q.repeat_count),
    .entry        (rd_data),
    .entry_next   (entry_next),
    .flags        (flags)
  );

  // Payload holds: command copy and result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_cnt   <= '0;
      proc_vld <= 1'b0;
      proc_idx <= '0;
      pend_vld <= 1'b0;
      fire_cnt <= '0;
      strobe   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          // Unknown operation: answer at once, no table access.
          strobe <= accept && (cmd.operation > OP_DELETE);
          if (accept) begin
            cmd_q    <= cmd;
            rd_cnt   <= '0;
            proc_vld <= 1'b0;
            pend_vld <= 1'b0;
            fire_cnt <= '0;
            if (cmd.operation > OP_DELETE) begin
              result.fired      <= 1'b0;
              result.fired_key  <= cmd.owner_key;
              result.slot_index <= '0;
              result.status     <= 1'b1;
              result.last       <= 1'b1;
            end else begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          // Advance the read pointer; read data for proc_idx arrives together with proc_idx.
          proc_vld <= issue;
          proc_idx <= rd_cnt[IDX_W-1:0];
          strobe   <= proc_vld && ((fire_beat && pend_vld) || search_done);
          if (issue) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
          end
          if (proc_vld) begin
            if (is_tick) begin
              if (fire_beat) begin
                // Hold each fire until the next one shows it is not last.
                if (pend_vld) begin
                  result <= pend;
                end
                pend_vld        <= 1'b1;
                pend.fired      <= 1'b1;
                pend.fired_key  <= rd_data.owner;
                pend.slot_index <= IDX_OUT_W'(proc_idx);
                pend.status     <= 1'b0;
                pend.last       <= 1'b0;
                fire_cnt        <= fire_cnt + FIRE_CNT_W'(1);
              end
              if (last_slot) begin
                state <= ST_FINISH;
              end
            end else if (search_done) begin
              result.fired      <= 1'b0;
              result.fired_key  <= cmd_q.owner_key;
              result.slot_index <= flags.hit ? IDX_OUT_W'(proc_idx) : '0;
              result.status     <= !flags.hit;
              result.last       <= 1'b1;
              state             <= ST_IDLE;
            end
          end
        end
        ST_FINISH: begin
          // Drop the held fire out as the closing beat.
          strobe <= pend_vld;
          if (pend_vld) begin
            result.fired      <= pend.fired;
            result.fired_key  <= pend.fired_key;
            result.slot_index <= pend.slot_index;
            result.status     <= pend.status;
            result.last       <= 1'b1;
          end
          pend_vld <= 1'b0;
          state    <= ST_IDLE;
        end
        default: begin
          strobe <= 1'b0;
          state  <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/trtt_slot_ram.sv
// ----------------------------------------------------------------------------
// trtt_slot_ram
// Slot memory, one read and one write port, registered read data.
// ----------------------------------------------------------------------------
module trtt_slot_ram
  import trtt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_t            rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  slot_t            wr_data
);

  slot_t                 mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] written;
  slot_t                 rd_q;
  logic                  rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Entries never written read as their reset contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_written ? rd_q : SLOT_RESET;

endmodule

FILE: rtl/trtt_slot_update.sv
// ----------------------------------------------------------------------------
// trtt_slot_update
// Per-slot update: tick advance and fire, or search match and rewrite.
// ----------------------------------------------------------------------------
module trtt_slot_update
  import trtt_pkg::*;
(
  input  logic [OP_W-1:0]     operation,
  input  logic [KEY_W-1:0]    owner_key,
  input  logic [PERIOD_W-1:0] period_ticks,
  input  logic [REPEAT_W-1:0] repeat_count,
  input  slot_t               entry,
  output slot_t               entry_next,
  output upd_flags_t          flags
);

  logic [COUNTER_W-1:0] per_ext;
  logic [COUNTER_W-1:0] cnt_adv;
  logic                 owner_empty;
  logic                 owner_match;

  assign per_ext     = COUNTER_W'(entry.period);
  assign cnt_adv     = (entry.counter <= per_ext) ? entry.counter + COUNTER_ONE
                                                  : entry.counter;
  assign owner_empty = (entry.owner == '0);
  assign owner_match = (entry.owner == owner_key);

  always_comb begin
    entry_next = entry;
    flags      = '0;
    case (operation)
      OP_TICK: begin
        if (entry.period != '0) begin
          entry_next.counter = cnt_adv;
          if (cnt_adv > per_ext) begin
            flags.fire         = 1'b1;
            entry_next.counter = COUNTER_ONE;
            if (entry.repeats_left != '0) begin
              entry_next.repeats_left = entry.repeats_left - REPEAT_W'(1);
              if (entry.repeats_left == REPEAT_W'(1)) begin
                entry_next.period = '0;
              end
            end
          end
        end
      end
      OP_SETUP, OP_START: begin
        flags.hit = (operation == OP_SETUP) ? owner_empty : (owner_match || owner_empty);
        entry_next.owner        = owner_key;
        entry_next.period       = period_ticks;
        entry_next.repeats_left = repeat_count;
      end
      OP_STOP, OP_DELETE: begin
        flags.hit               = owner_match;
        entry_next.counter      = COUNTER_ONE;
        entry_next.period       = '0;
        entry_next.repeats_left = '0;
        if (operation == OP_DELETE) begin
          entry_next.owner = '0;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

endmodule

FILE: rtl/trtt_checker.sv
// ----------------------------------------------------------------------------
// trtt_checker
// Port-level checks of the timer table, bound to the top level.
// ----------------------------------------------------------------------------
`include "tick_driven_repeat_timer_table_core_macros.svh"

module trtt_checker
  import trtt_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input cmd_t    cmd,
  input logic    busy,
  input logic    strobe,
  input result_t result
);

  logic table_op;
  logic unknown_op;

  assign table_op   = (cmd.operation == OP_TICK) || (cmd.operation == OP_SETUP) ||
                      (cmd.operation == OP_START) || (cmd.operation == OP_STOP) ||
                      (cmd.operation == OP_DELETE);
  assign unknown_op = !table_op;

  // A fire beat never reports a failure.
  `TRTT_ASSERT_NOW(a_fire_ok, clk, rst, strobe && result.fired, !result.status)
  // Non-fire beats are the single answer of a command.
  `TRTT_ASSERT_NOW(a_single_last, clk, rst, strobe && !result.fired, result.last)
  // A table command walks the memory.
  `TRTT_ASSERT_NEXT(a_walk_busy, clk, rst, start && !busy && table_op, busy)
  // An unknown operation is answered on the next cycle.
  `TRTT_ASSERT_NEXT(a_unknown_ans, clk, rst, start && !busy && unknown_op,
    strobe && result.status && !busy)
  // A beat that is not last is followed by more walking or the closing beat.
  `TRTT_ASSERT_NEXT(a_more_follow, clk, rst, strobe && !result.last, busy || strobe)

endmodule

bind tick_driven_repeat_timer_table_core trtt_checker u_trtt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .cmd    (cmd),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

FILE: tb/sv/tick_driven_repeat_timer_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table core testbench
// Drives command beats into the timer table and checks every result beat
// against an in-bench model of the slot table, in order, field by field.
// A short directed plan comes first, followed by random traffic built around
// a small pool of owner keys, so that slots fill up, fire, run out of repeats
// and get stopped and deleted again.
// ----------------------------------------------------------------------------
module tick_driven_repeat_timer_table_core_test;
  import trtt_pkg::*;

  localparam int SLOTS        = SLOT_COUNT_DEF;
  localparam int RANDOM_ITEMS = 320;
  localparam int REPORT_MAX   = 10;
  localparam int CYCLE_LIMIT  = 100000;
  // Longest walk is a tick, which ends with its closing beat.
  localparam int DRAIN_CYCLES = SLOTS + 12;

  // Result status codes.
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  // Operation codes the block does not define; it answers them with a miss.
  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  // Owner keys that the random part mostly draws from. They match the keys
  // that the directed part leaves in the table, so every slot can be reached.
  localparam logic [8*KEY_W-1:0] HOT_KEYS =
    {8'hFF, 8'hAA, 8'h80, 8'h05, 8'h04, 8'h03, 8'h02, 8'h01};

  typedef struct {
    cmd_t    c;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic    clk;
  logic    rst;
  logic    start;
  cmd_t    cmd;
  logic    busy;
  logic    strobe;
  result_t result;

  // Model copy of the slot table.
  logic [KEY_W-1:0]     tbl_owner   [SLOTS];
  logic [COUNTER_W-1:0] tbl_count   [SLOTS];
  logic [PERIOD_W-1:0]  tbl_period  [SLOTS];
  logic [REPEAT_W-1:0]  tbl_repeats [SLOTS];

  result_t     step_beats[$];   // beats caused by the command just taken
  result_t     due_results[$];  // beats still owed by the block, oldest first
  plan_row_t   plan[$];

  int          gap_pct;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned beats_seen;
  int unsigned fire_beats;
  int unsigned cycle_count;

  tick_driven_repeat_timer_table_core #(
    .SLOT_COUNT(SLOTS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .strobe(strobe),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run: a hung busy or a lost beat ends here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycle_count,
               due_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_owner[i]   = '0;
      tbl_count[i]   = COUNTER_ONE;
      tbl_period[i]  = '0;
      tbl_repeats[i] = '0;
    end
  endfunction

  // Apply one command to the model table and leave its beats in step_beats.
  function automatic void predict_timer_results(cmd_t c);
    result_t b;
    bit      hit;
    int      hit_slot;
    b = '0;
    hit_slot = -1;
    step_beats.delete();
    case (c.operation)
      OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_period[i] != '0) begin
            // Advance while at or below the period; passing it fires.
            if (tbl_count[i] <= {1'b0, tbl_period[i]})
              tbl_count[i] = tbl_count[i] + 1'b1;
            if (tbl_count[i] > {1'b0, tbl_period[i]}) begin
              tbl_count[i] = COUNTER_ONE;
              if (step_beats.size() < RESULT_MAX) begin
                b.fired      = 1'b1;
                b.fired_key  = tbl_owner[i];
                b.slot_index = IDX_OUT_W'(i);
                b.status     = STATUS_DONE;
                b.last       = 1'b0;
                step_beats.push_back(b);
              end
              // Count down a finite repeat; disarm when it runs out.
              if (tbl_repeats[i] != '0) begin
                tbl_repeats[i] = tbl_repeats[i] - 1'b1;
                if (tbl_repeats[i] == '0)
                  tbl_period[i] = '0;
              end
            end
          end
        end
        if (step_beats.size() > 0)
          step_beats[step_beats.size() - 1].last = 1'b1;
      end
      OP_SETUP, OP_START, OP_STOP, OP_DELETE: begin
        for (int i = 0; i < SLOTS && hit_slot < 0; i++) begin
          if (c.operation == OP_SETUP)
            hit = (tbl_owner[i] == '0);
          else if (c.operation == OP_START)
            hit = (tbl_owner[i] == c.owner_key) || (tbl_owner[i] == '0);
          else
            hit = (tbl_owner[i] == c.owner_key);
          if (hit) begin
            hit_slot = i;
            if (c.operation == OP_SETUP || c.operation == OP_START) begin
              // Start keeps the running count, even above the new period.
              tbl_owner[i]   = c.owner_key;
              tbl_period[i]  = c.period_ticks;
              tbl_repeats[i] = c.repeat_count;
            end else begin
              tbl_count[i]   = COUNTER_ONE;
              tbl_period[i]  = '0;
              tbl_repeats[i] = '0;
              if (c.operation == OP_DELETE)
                tbl_owner[i] = '0;
            end
          end
        end
        b.fired      = 1'b0;
        b.fired_key  = c.owner_key;
        b.slot_index = (hit_slot < 0) ? '0 : IDX_OUT_W'(hit_slot);
        b.status     = (hit_slot < 0) ? STATUS_MISS : STATUS_DONE;
        b.last       = 1'b1;
        step_beats.push_back(b);
      end
      default: begin
        // Undefined operation: no table change, answered as a miss.
        b.fired      = 1'b0;
        b.fired_key  = c.owner_key;
        b.slot_index = '0;
        b.status     = STATUS_MISS;
        b.last       = 1'b1;
        step_beats.push_back(b);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Add one directed row; a typed row carries its single answer beat.
  function automatic void plan_step(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                    logic [PERIOD_W-1:0] per,
                                    logic [REPEAT_W-1:0] rep, bit typed,
                                    logic [IDX_OUT_W-1:0] slot, logic status);
    plan_row_t r;
    r.c.operation    = op;
    r.c.owner_key    = key;
    r.c.period_ticks = per;
    r.c.repeat_count = rep;
    r.typed          = typed;
    r.want.fired      = 1'b0;
    r.want.fired_key  = key;
    r.want.slot_index = slot;
    r.want.status     = status;
    r.want.last       = 1'b1;
    plan.push_back(r);
  endfunction

  // Random command: mostly ticks and table operations on pooled keys, with
  // short periods so slots fire often; some full-range values and noise.
  function automatic cmd_t pick_cmd();
    cmd_t        c;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45)      c.operation = OP_TICK;
    else if (roll < 58) c.operation = OP_SETUP;
    else if (roll < 73) c.operation = OP_START;
    else if (roll < 85) c.operation = OP_STOP;
    else if (roll < 95) c.operation = OP_DELETE;
    else                c.operation = OP_W'($urandom_range(OP_RSVD7, OP_RSVD5));

    roll = $urandom_range(99);
    if (roll < 75)      c.owner_key = HOT_KEYS[$urandom_range(7)*KEY_W +: KEY_W];
    else if (roll < 85) c.owner_key = '0;
    else                c.owner_key = KEY_W'($urandom);

    roll = $urandom_range(99);
    if (roll < 10)      c.period_ticks = '0;
    else if (roll < 60) c.period_ticks = PERIOD_W'($urandom_range(4, 1));
    else if (roll < 75) c.period_ticks = PERIOD_W'($urandom_range(20, 5));
    else                c.period_ticks = PERIOD_W'($urandom);

    roll = $urandom_range(99);
    if (roll < 50)      c.repeat_count = '0;
    else if (roll < 85) c.repeat_count = REPEAT_W'($urandom_range(3, 1));
    else                c.repeat_count = REPEAT_W'($urandom);
    return c;
  endfunction

  // Present one command beat from a falling edge, hold it until taken, then
  // book its expected beats. Returns on the falling edge after the take.
  task automatic issue(cmd_t c, bit typed, result_t want);
    // Idle the sender for a random stretch first.
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    // Hold until an edge with busy low takes the beat.
    do @(posedge clk); while (busy);
    predict_timer_results(c);
    if (typed)
      due_results.push_back(want);
    else
      foreach (step_beats[i]) due_results.push_back(step_beats[i]);
    items_sent++;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic log_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t %s: want fired=%0d key=%02h slot=%0d status=%0d last=%0d",
               $realtime, what, want.fired, want.fired_key, want.slot_index,
               want.status, want.last,
               "\n             got  fired=%0d key=%02h slot=%0d status=%0d last=%0d",
               got.fired, got.fired_key, got.slot_index, got.status, got.last);
  endtask

  // Take every strobed beat at the edge that ends its cycle; the block
  // cannot be held off, so match it against the oldest beat owed.
  always @(posedge clk) begin
    result_t want;
    if (!rst && strobe) begin
      beats_seen++;
      if (result.fired === 1'b1)
        fire_beats++;
      if (due_results.size() == 0) begin
        log_mismatch("unexpected beat", '0, result);
      end else begin
        want = due_results.pop_front();
        if (result.fired !== want.fired || result.fired_key !== want.fired_key ||
            result.slot_index !== want.slot_index ||
            result.status !== want.status || result.last !== want.last)
          log_mismatch("beat mismatch", want, result);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    cmd         = '0;
    gap_pct     = 19;
    mismatches  = 0;
    items_sent  = 0;
    beats_seen  = 0;
    fire_beats  = 0;
    clear_table();

    // Directed plan. Typed rows check the answer beat written here; the
    // rest (ticks mostly) go through the model.
    //        op          key    period    rep    typed slot  status
    // Miss on an empty table, then key zero hits the first empty slot.
    plan_step(OP_STOP,    8'h55, 16'h0000, 8'h00, 1'b1, 3'd0, STATUS_MISS);
    plan_step(OP_DELETE,  8'h00, 16'h0000, 8'h00, 1'b1, 3'd0, STATUS_DONE);
    // Arm three slots: fire every tick, every second tick three times, once.
    plan_step(OP_SETUP,   8'hFF, 16'h0001, 8'h00, 1'b1, 3'd0, STATUS_DONE);
    plan_step(OP_SETUP,   8'h01, 16'h0002, 8'h03, 1'b1, 3'd1, STATUS_DONE);
    plan_step(OP_START,   8'h80, 16'h0001, 8'h01, 1'b1, 3'd2, STATUS_DONE);
    plan_step(OP_TICK,    8'h00, 16'h0000, 8'h00, 1'b0, 3'd0, STATUS_DONE);
    plan_step(OP_TICK,    8'h00, 16'h0000, 8'h00, 1'b0, 3'd0, STATUS_DONE);
    // Restart slot 1 at the longest period, run its count up, then lower the
    // period under the count so it fires on the very next tick.
    plan_step(OP_START,   8'h01, 16'hFFFF, 8'hFF, 1'b1, 3'd1, STATUS_DONE);
    plan_step(OP_TICK,    8'h00, 16'h0000, 8'h00, 1'b0, 3'd0, STATUS_DONE);
    plan_step(OP_TICK,    8'h00, 16'h0000, 8'h00, 1'b0, 3'd0, STATUS_DONE);
    plan_step(OP_START,   8'h01, 16'h0001, 8'h02, 1'b1, 3'd1, STATUS_DONE);
    plan_step(OP_TICK,    8'h00, 16'h0000, 8'h00, 1'b0, 3'd0, STATUS_DONE);
    // A slot set up with key zero still reads as empty and is taken again.
    plan_step(OP_SETUP,   8'h00, 16'h0005, 8'h00, 1'b1, 3'd3, STATUS_DONE);
    plan_step(OP_SETUP,   8'hAA, 16'h0003, 8'h00, 1'b1, 3'd3, STATUS_DONE);
    // Undefined operations change nothing.
    plan_step(OP_RSVD5,   8'h12, 16'h1234, 8'h56, 1'b1, 3'd0, STATUS_MISS);
    plan_step(OP_RSVD7,   8'hED, 16'hFFFF, 8'hFF, 1'b1, 3'd0, STATUS_MISS);
    plan_step(OP_STOP,    8'hFF, 16'h0000, 8'h00, 1'b1, 3'd0, STATUS_DONE);
    plan_step(OP_DELETE,  8'h01, 16'h0000, 8'h00, 1'b1, 3'd1, STATUS_DONE);
    plan_step(OP_TICK,    8'h00, 16'h0000, 8'h00, 1'b0, 3'd0, STATUS_DONE);
    // Fill every slot, then a setup finds no room.
    plan_step(OP_SETUP,   8'h01, 16'h0000, 8'h00, 1'b1, 3'd1, STATUS_DONE);
    plan_step(OP_SETUP,   8'h02, 16'hFFFF, 8'hFF, 1'b1, 3'd4, STATUS_DONE);
    plan_step(OP_SETUP,   8'h03, 16'h0002, 8'h00, 1'b1, 3'd5, STATUS_DONE);
    plan_step(OP_SETUP,   8'h04, 16'h8000, 8'h01, 1'b1, 3'd6, STATUS_DONE);
    plan_step(OP_SETUP,   8'h05, 16'h0001, 8'h00, 1'b1, 3'd7, STATUS_DONE);
    plan_step(OP_SETUP,   8'h06, 16'h0004, 8'h00, 1'b1, 3'd0, STATUS_MISS);

    // Hold reset, then release it on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) issue(plan[i].c, plan[i].typed, plan[i].want);

    // Random traffic in three stretches: light sender gaps, heavy gaps, none.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3)
        gap_pct = 70;
      if (n == 2 * RANDOM_ITEMS / 3)
        gap_pct = 0;
      issue(pick_cmd(), 1'b0, '0);
    end
    start <= 1'b0;

    // Drain: wait out owed beats and the last walk, then catch strays.
    while (due_results.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      mismatches += due_results.size();
      $display("%0d expected beats never arrived", due_results.size());
    end

    $display("covered %0d commands (%0d directed), %0d result beats, %0d fires",
             items_sent, plan.size(), beats_seen, fire_beats);
    $display("%0d mismatches over %0d cycles", mismatches, cycle_count);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
